/* rtl/core/motion_controller_reply_parser_defines.svh */
`ifndef MOTION_CONTROLLER_REPLY_PARSER_DEFINES_SVH
`define MOTION_CONTROLLER_REPLY_PARSER_DEFINES_SVH

// Check prop on every clock edge outside reset.
`define MCRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When ante holds, cons must hold on the next clock edge.
`define MCRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mcrp_pkg.sv */
package mcrp_pkg;

  localparam int ChanW  = 2;
  localparam int ByteW  = 8;
  localparam int EventW = 4;
  localparam int AxisW  = 2;
  localparam int ValueW = 16;

  typedef enum logic [4:0] {
    ST_FIND = 5'd0,
    ST_HOM1 = 5'd1,
    ST_HOM2 = 5'd2,
    ST_OK1  = 5'd3,
    ST_OK2  = 5'd4,
    ST_OK3  = 5'd5,
    ST_RST1 = 5'd6,
    ST_RST2 = 5'd7,
    ST_AL1  = 5'd8,
    ST_AL2  = 5'd9,
    ST_AL3  = 5'd10,
    ST_AL4  = 5'd11,
    ST_AL5  = 5'd12,
    ST_WP1  = 5'd13,
    ST_WP2  = 5'd14,
    ST_WP3  = 5'd15,
    ST_WP4  = 5'd16,
    ST_WP5  = 5'd17,
    ST_STAT = 5'd18
  } parse_state_e;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } num_phase_e;

  typedef enum logic [3:0] {
    EV_HOMING   = 4'd0,
    EV_OK       = 4'd1,
    EV_RESET    = 4'd2,
    EV_SOFT     = 4'd3,
    EV_DOOR     = 4'd4,
    EV_HARD     = 4'd5,
    EV_HOMEFAIL = 4'd6,
    EV_AXIS     = 4'd7,
    EV_END      = 4'd8,
    EV_RUN      = 4'd9,
    EV_IDLE     = 4'd10,
    EV_ALARM    = 4'd11,
    EV_HOLD     = 4'd12
  } event_e;

  typedef enum logic {
    FN_BYTE  = 1'b0,
    FN_CLEAR = 1'b1
  } func_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LO_O   = 8'h6f;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_W   = 8'h57;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_LO_K   = 8'h6b;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_L   = 8'h4c;
  localparam logic [7:0] CH_UP_P   = 8'h50;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_UP_S   = 8'h53;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_UP_I   = 8'h49;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;

endpackage

/* rtl/core/mcrp_if.sv */
interface mcrp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [mcrp_pkg::ChanW-1:0]  channel;
  logic [mcrp_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output func, output channel, output rx_byte, input ready);
  modport sink   (input valid, input func, input channel, input rx_byte, output ready);
endinterface

interface mcrp_out_if;
  logic                               valid;
  logic                               ready;
  logic [mcrp_pkg::ChanW-1:0]         channel_out;
  logic [mcrp_pkg::EventW-1:0]        event_code;
  logic [mcrp_pkg::AxisW-1:0]         axis_index;
  logic signed [mcrp_pkg::ValueW-1:0] axis_value;

  modport source (output valid, output channel_out, output event_code, output axis_index,
                  output axis_value, input ready);
  modport sink   (input valid, input channel_out, input event_code, input axis_index,
                  input axis_value, output ready);
endinterface

/* rtl/core/motion_controller_reply_parser.sv */
// Reply parser for the serial links of up to CHANNELS motion controllers.
// Input channel in_i: one beat carries a received byte for one link, or a
// clear command (func = 1) that returns that link's parser to its find state.
// Output channel out_o: one beat per recognized event (homing, ok, reset,
// alarm kinds, status kinds, one beat per position number, report end).
// Beats for a link number at or above CHANNELS are dropped.
// An accepted beat passes the input register, then the result register, before
// its event shows on out_o. Throughput: one beat per cycle while out_o is not
// stalled; the per-link state is read, updated and written back between the
// two registers, so back-to-back beats on the same link need no bypass.
// The result register parts the two sides: while a result waits, one more
// input beat is taken into the input register, then in_i.ready drops until
// out_o.ready drains the result.
// Reset clears the input and result valid flags and puts every link's parser
// in its find state with an empty number.
`include "motion_controller_reply_parser_defines.svh"

module motion_controller_reply_parser #(
  parameter int CHANNELS     = 3,
  parameter int NUMBER_CHARS = 15,
  parameter int AXES         = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcrp_in_if.sink           in_i,
  mcrp_out_if.source        out_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CcW    = $clog2(NUMBER_CHARS + 1);
  localparam int ValW   = mcrp_pkg::ValueW;
  localparam int AxW    = mcrp_pkg::AxisW;

  // Input register
  logic                          s1_valid_q;
  logic                          s1_func_q;
  logic [mcrp_pkg::ChanW-1:0]    s1_ch_q;
  logic [mcrp_pkg::ByteW-1:0]    s1_byte_q;

  // Per-link parser state
  mcrp_pkg::parse_state_e        st_q  [CHANNELS];
  logic [mcrp_pkg::AxisW-1:0]    ax_q  [CHANNELS];
  logic [CcW-1:0]                cc_q  [CHANNELS];
  logic [ValW-1:0]               acc_q [CHANNELS];
  mcrp_pkg::num_phase_e          ph_q  [CHANNELS];
  logic                          neg_q [CHANNELS];

  // Result register
  logic                          out_valid_q;
  logic [mcrp_pkg::ChanW-1:0]    out_ch_q;
  mcrp_pkg::event_e              out_ev_q;
  logic [mcrp_pkg::AxisW-1:0]    out_ax_q;
  logic [ValW-1:0]               out_val_q;

  logic                          in_fire;
  logic                          s1_adv;
  logic                          ch_ok;
  logic                          s1_fire;
  logic [ChIdxW-1:0]             idx;

  mcrp_pkg::parse_state_e        st_cur, st_d;
  logic [mcrp_pkg::AxisW-1:0]    ax_cur, ax_d;
  logic [CcW-1:0]                cc_cur, cc_d;
  logic [ValW-1:0]               acc_cur, acc_d;
  mcrp_pkg::num_phase_e          ph_cur, ph_d;
  logic                          neg_cur, neg_d;

  logic                          emit;
  mcrp_pkg::event_e              ev_d;
  logic [mcrp_pkg::AxisW-1:0]    ev_ax_d;
  logic [ValW-1:0]               ev_val_d;

  logic                          is_digit;
  logic                          is_blank;
  logic [ValW-1:0]               acc_times10;

  assign s1_adv   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;
  assign ch_ok    = 32'(s1_ch_q) < CHANNELS;
  assign s1_fire  = s1_valid_q && s1_adv && ch_ok;
  assign idx      = ch_ok ? ChIdxW'(s1_ch_q) : '0;

  assign st_cur  = st_q[idx];
  assign ax_cur  = ax_q[idx];
  assign cc_cur  = cc_q[idx];
  assign acc_cur = acc_q[idx];
  assign ph_cur  = ph_q[idx];
  assign neg_cur = neg_q[idx];

  assign is_digit = (s1_byte_q >= mcrp_pkg::CH_ZERO) && (s1_byte_q <= mcrp_pkg::CH_NINE);
  assign is_blank = (s1_byte_q == mcrp_pkg::CH_SPACE) ||
                    ((s1_byte_q >= mcrp_pkg::CH_TAB) && (s1_byte_q <= mcrp_pkg::CH_CR));
  assign acc_times10 = (acc_cur << 3) + (acc_cur << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= in_i.func;
      s1_ch_q   <= in_i.channel;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  always_comb begin
    st_d     = st_cur;
    ax_d     = ax_cur;
    cc_d     = cc_cur;
    acc_d    = acc_cur;
    ph_d     = ph_cur;
    neg_d    = neg_cur;
    emit     = 1'b0;
    ev_d     = mcrp_pkg::EV_HOMING;
    ev_ax_d  = '0;
    ev_val_d = '0;

    if (s1_func_q == mcrp_pkg::FN_CLEAR) begin
      st_d  = mcrp_pkg::ST_FIND;
      ax_d  = '0;
      cc_d  = '0;
      acc_d = '0;
      ph_d  = mcrp_pkg::PH_SPACE;
      neg_d = 1'b0;
    end else begin
      unique case (st_cur)
        mcrp_pkg::ST_FIND: begin
          if (s1_byte_q == mcrp_pkg::CH_DOLLAR)      st_d = mcrp_pkg::ST_HOM1;
          else if (s1_byte_q == mcrp_pkg::CH_LO_O)   st_d = mcrp_pkg::ST_OK1;
          else if (s1_byte_q == mcrp_pkg::CH_UP_R)   st_d = mcrp_pkg::ST_RST1;
          else if (s1_byte_q == mcrp_pkg::CH_UP_W)   st_d = mcrp_pkg::ST_WP1;
          else if (s1_byte_q == mcrp_pkg::CH_LT)     st_d = mcrp_pkg::ST_STAT;
          else if (s1_byte_q == mcrp_pkg::CH_UP_A)   st_d = mcrp_pkg::ST_AL1;
        end
        mcrp_pkg::ST_HOM1: begin
          st_d = (s1_byte_q == mcrp_pkg::CH_UP_H) ? mcrp_pkg::ST_HOM2 : mcrp_pkg::ST_FIND;
        end
        mcrp_pkg::ST_HOM2: begin
          if (s1_byte_q == mcrp_pkg::CH_LF) begin
            st_d = mcrp_pkg::ST_FIND;
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_HOMING;
          end
        end
        mcrp_pkg::ST_OK1: begin
          st_d = (s1_byte_q == mcrp_pkg::CH_LO_K) ? mcrp_pkg::ST_OK2 : mcrp_pkg::ST_FIND;
        end
        mcrp_pkg::ST_OK2: begin
          st_d = (s1_byte_q == mcrp_pkg::CH_CR) ? mcrp_pkg::ST_OK3 : mcrp_pkg::ST_FIND;
        end
        mcrp_pkg::ST_OK3: begin
          if (s1_byte_q == mcrp_pkg::CH_LF) begin
            st_d = mcrp_pkg::ST_FIND;
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_OK;
          end
        end
        mcrp_pkg::ST_RST1: begin
          st_d = (s1_byte_q == mcrp_pkg::CH_LO_E) ? mcrp_pkg::ST_RST2 : mcrp_pkg::ST_FIND;
        end
        mcrp_pkg::ST_RST2: begin
          if (s1_byte_q == mcrp_pkg::CH_LF) begin
            st_d = mcrp_pkg::ST_FIND;
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_RESET;
          end
        end
        mcrp_pkg::ST_AL1: begin
          st_d = (s1_byte_q == mcrp_pkg::CH_UP_L) ? mcrp_pkg::ST_AL2 : mcrp_pkg::ST_FIND;
        end
        mcrp_pkg::ST_AL2: begin
          if (s1_byte_q == mcrp_pkg::CH_COLON) st_d = mcrp_pkg::ST_AL3;
        end
        mcrp_pkg::ST_AL3: begin
          st_d = (s1_byte_q == mcrp_pkg::CH_SPACE) ? mcrp_pkg::ST_AL4 : mcrp_pkg::ST_FIND;
        end
        mcrp_pkg::ST_AL4: begin
          // hold until one of the alarm letters shows up
          if (s1_byte_q == mcrp_pkg::CH_UP_H) begin
            st_d = mcrp_pkg::ST_AL5;
          end else if (s1_byte_q == mcrp_pkg::CH_UP_S) begin
            st_d = mcrp_pkg::ST_FIND;
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_SOFT;
          end else if (s1_byte_q == mcrp_pkg::CH_UP_D) begin
            st_d = mcrp_pkg::ST_FIND;
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_DOOR;
          end
        end
        mcrp_pkg::ST_AL5: begin
          st_d = mcrp_pkg::ST_FIND;
          if (s1_byte_q == mcrp_pkg::CH_LO_A) begin
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_HARD;
          end else if (s1_byte_q == mcrp_pkg::CH_LO_O) begin
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_HOMEFAIL;
          end
        end
        mcrp_pkg::ST_WP1: begin
          st_d = (s1_byte_q == mcrp_pkg::CH_UP_P) ? mcrp_pkg::ST_WP2 : mcrp_pkg::ST_FIND;
        end
        mcrp_pkg::ST_WP2: begin
          if (s1_byte_q == mcrp_pkg::CH_COLON) st_d = mcrp_pkg::ST_WP3;
        end
        mcrp_pkg::ST_WP3: begin
          if ((s1_byte_q == mcrp_pkg::CH_COMMA) || (s1_byte_q == mcrp_pkg::CH_GT)) begin
            emit     = 1'b1;
            ev_d     = mcrp_pkg::EV_AXIS;
            ev_ax_d  = ax_cur;
            ev_val_d = neg_cur ? (~acc_cur + ValW'(1)) : acc_cur;
            cc_d     = '0;
            acc_d    = '0;
            ph_d     = mcrp_pkg::PH_SPACE;
            neg_d    = 1'b0;
            if (32'(ax_cur) + 32'd1 >= AXES) begin
              ax_d = '0;
              st_d = mcrp_pkg::ST_WP4;
            end else begin
              ax_d = ax_cur + AxW'(1);
            end
          end else if (32'(cc_cur) < NUMBER_CHARS) begin
            cc_d = cc_cur + CcW'(1);
            unique case (ph_cur)
              mcrp_pkg::PH_SPACE: begin
                if (is_blank) begin
                  ph_d = mcrp_pkg::PH_SPACE;
                end else if (s1_byte_q == mcrp_pkg::CH_MINUS) begin
                  neg_d = 1'b1;
                  ph_d  = mcrp_pkg::PH_DIGITS;
                end else if (s1_byte_q == mcrp_pkg::CH_PLUS) begin
                  ph_d = mcrp_pkg::PH_DIGITS;
                end else if (is_digit) begin
                  ph_d  = mcrp_pkg::PH_DIGITS;
                  acc_d = acc_times10 + ValW'(s1_byte_q[3:0]);
                end else begin
                  ph_d = mcrp_pkg::PH_DONE;
                end
              end
              mcrp_pkg::PH_DIGITS: begin
                if (is_digit) acc_d = acc_times10 + ValW'(s1_byte_q[3:0]);
                else          ph_d  = mcrp_pkg::PH_DONE;
              end
              default: begin
                ph_d = ph_cur;
              end
            endcase
          end
        end
        mcrp_pkg::ST_WP4: begin
          if (s1_byte_q == mcrp_pkg::CH_CR) st_d = mcrp_pkg::ST_WP5;
        end
        mcrp_pkg::ST_WP5: begin
          if (s1_byte_q == mcrp_pkg::CH_LF) begin
            st_d = mcrp_pkg::ST_FIND;
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_END;
          end
        end
        mcrp_pkg::ST_STAT: begin
          st_d = mcrp_pkg::ST_FIND;
          if (s1_byte_q == mcrp_pkg::CH_UP_R) begin
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_RUN;
          end else if (s1_byte_q == mcrp_pkg::CH_UP_I) begin
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_IDLE;
          end else if (s1_byte_q == mcrp_pkg::CH_UP_A) begin
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_ALARM;
          end else if (s1_byte_q == mcrp_pkg::CH_UP_H) begin
            emit = 1'b1;
            ev_d = mcrp_pkg::EV_HOLD;
          end
        end
        default: begin
          st_d = mcrp_pkg::ST_FIND;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_q[i]  <= mcrp_pkg::ST_FIND;
        ax_q[i]  <= '0;
        cc_q[i]  <= '0;
        acc_q[i] <= '0;
        ph_q[i]  <= mcrp_pkg::PH_SPACE;
        neg_q[i] <= 1'b0;
      end
    end else if (s1_fire) begin
      st_q[idx]  <= st_d;
      ax_q[idx]  <= ax_d;
      cc_q[idx]  <= cc_d;
      acc_q[idx] <= acc_d;
      ph_q[idx]  <= ph_d;
      neg_q[idx] <= neg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_ch_q  <= s1_ch_q;
      out_ev_q  <= ev_d;
      out_ax_q  <= ev_ax_d;
      out_val_q <= ev_val_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.event_code  = out_ev_q;
  assign out_o.axis_index  = out_ax_q;
  assign out_o.axis_value  = out_val_q;

  `MCRP_ASSERT(a_out_chan_range, !out_valid_q || (32'(out_ch_q) < CHANNELS),
    "result beat carries a link number out of range")
  `MCRP_ASSERT(a_out_non_axis_zero,
    !out_valid_q || (out_ev_q == mcrp_pkg::EV_AXIS) || ((out_ax_q == '0) && (out_val_q == '0)),
    "non-axis event carries axis index or value")
  `MCRP_ASSERT(a_axis_cnt_range, !(s1_valid_q && ch_ok) || (32'(ax_cur) < AXES),
    "axis counter of the link beyond the axis count")
  `MCRP_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv,
    s1_valid_q && $stable(s1_ch_q) && $stable(s1_byte_q),
    "input register lost its beat while the result was stalled")

endmodule

/* tb/motion_controller_reply_parser_tb.sv */
`timescale 1ns / 100ps

module motion_controller_reply_parser_tb;
  import mcrp_pkg::*;

  localparam int CHANNELS     = 3;
  localparam int NUMBER_CHARS = 15;
  localparam int AXES         = 3;
  localparam int RANDOM_BEATS = 1450;
  localparam int QUIET_TAIL   = 150;

  localparam logic [7:0] CH_DOT = 8'h2e;

  typedef struct packed {
    logic [ChanW-1:0]  chan;
    event_e            ev;
    logic [AxisW-1:0]  axis;
    logic [ValueW-1:0] value;
  } reply_t;

  typedef logic [7:0] byte_q_t[$];

  class event_scoreboard;
    reply_t       pending_events[$];
    parse_state_e link_state[CHANNELS];
    logic [1:0]   axis_cnt[CHANNELS];
    logic [3:0]   char_cnt[CHANNELS];
    logic [15:0]  number[CHANNELS];
    num_phase_e   number_phase[CHANNELS];
    logic         number_neg[CHANNELS];
    int           errors;

    function new();
      errors = 0;
      for (int c = 0; c < CHANNELS; c++) clear_link(c);
    endfunction

    function void clear_number(int c);
      char_cnt[c]     = '0;
      number[c]       = '0;
      number_phase[c] = PH_SPACE;
      number_neg[c]   = 1'b0;
    endfunction

    function void clear_link(int c);
      link_state[c] = ST_FIND;
      axis_cnt[c]   = '0;
      clear_number(c);
    endfunction

    function void push_event(int c, event_e ev, logic [1:0] ax, logic [15:0] val);
      reply_t r;
      r.chan  = 2'(c);
      r.ev    = ev;
      r.axis  = ax;
      r.value = val;
      pending_events.push_back(r);
    endfunction

    // atoi-style conversion: blanks, optional sign, digits until a non-digit
    function void accumulate_char(int c, logic [7:0] b);
      logic digit;
      logic blank;
      digit = (b >= CH_ZERO) && (b <= CH_NINE);
      blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      if (int'(char_cnt[c]) >= NUMBER_CHARS) return;
      char_cnt[c]++;
      case (number_phase[c])
        PH_SPACE: begin
          if (blank) begin
          end else if (b == CH_MINUS) begin
            number_neg[c]   = 1'b1;
            number_phase[c] = PH_DIGITS;
          end else if (b == CH_PLUS) begin
            number_phase[c] = PH_DIGITS;
          end else if (digit) begin
            number_phase[c] = PH_DIGITS;
            number[c] = number[c] * 16'd10 + {8'd0, b - CH_ZERO};
          end else begin
            number_phase[c] = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (digit) number[c] = number[c] * 16'd10 + {8'd0, b - CH_ZERO};
          else number_phase[c] = PH_DONE;
        end
        default: ;
      endcase
    endfunction

    function void predict_beat(func_e fn, logic [1:0] ch, logic [7:0] b);
      int          c;
      logic [15:0] val;
      logic [1:0]  ax;
      c = int'(ch);
      if (c >= CHANNELS) return;
      if (fn == FN_CLEAR) begin
        clear_link(c);
        return;
      end
      case (link_state[c])
        ST_FIND: begin
          if (b == CH_DOLLAR) link_state[c] = ST_HOM1;
          else if (b == CH_LO_O) link_state[c] = ST_OK1;
          else if (b == CH_UP_R) link_state[c] = ST_RST1;
          else if (b == CH_UP_W) link_state[c] = ST_WP1;
          else if (b == CH_LT) link_state[c] = ST_STAT;
          else if (b == CH_UP_A) link_state[c] = ST_AL1;
        end
        ST_HOM1: begin
          if (b == CH_UP_H) link_state[c] = ST_HOM2;
          else link_state[c] = ST_FIND;
        end
        ST_HOM2: begin
          if (b == CH_LF) begin
            link_state[c] = ST_FIND;
            push_event(c, EV_HOMING, 2'd0, 16'd0);
          end
        end
        ST_OK1: begin
          if (b == CH_LO_K) link_state[c] = ST_OK2;
          else link_state[c] = ST_FIND;
        end
        ST_OK2: begin
          if (b == CH_CR) link_state[c] = ST_OK3;
          else link_state[c] = ST_FIND;
        end
        ST_OK3: begin
          if (b == CH_LF) begin
            link_state[c] = ST_FIND;
            push_event(c, EV_OK, 2'd0, 16'd0);
          end
        end
        ST_RST1: begin
          if (b == CH_LO_E) link_state[c] = ST_RST2;
          else link_state[c] = ST_FIND;
        end
        ST_RST2: begin
          if (b == CH_LF) begin
            link_state[c] = ST_FIND;
            push_event(c, EV_RESET, 2'd0, 16'd0);
          end
        end
        ST_AL1: begin
          if (b == CH_UP_L) link_state[c] = ST_AL2;
          else link_state[c] = ST_FIND;
        end
        ST_AL2: if (b == CH_COLON) link_state[c] = ST_AL3;
        ST_AL3: begin
          if (b == CH_SPACE) link_state[c] = ST_AL4;
          else link_state[c] = ST_FIND;
        end
        ST_AL4: begin
          if (b == CH_UP_H) begin
            link_state[c] = ST_AL5;
          end else if (b == CH_UP_S) begin
            link_state[c] = ST_FIND;
            push_event(c, EV_SOFT, 2'd0, 16'd0);
          end else if (b == CH_UP_D) begin
            link_state[c] = ST_FIND;
            push_event(c, EV_DOOR, 2'd0, 16'd0);
          end
        end
        ST_AL5: begin
          link_state[c] = ST_FIND;
          if (b == CH_LO_A) push_event(c, EV_HARD, 2'd0, 16'd0);
          else if (b == CH_LO_O) push_event(c, EV_HOMEFAIL, 2'd0, 16'd0);
        end
        ST_WP1: begin
          if (b == CH_UP_P) link_state[c] = ST_WP2;
          else link_state[c] = ST_FIND;
        end
        ST_WP2: if (b == CH_COLON) link_state[c] = ST_WP3;
        ST_WP3: begin
          if (b == CH_COMMA || b == CH_GT) begin
            ax  = axis_cnt[c];
            val = number_neg[c] ? 16'd0 - number[c] : number[c];
            push_event(c, EV_AXIS, ax, val);
            clear_number(c);
            if (int'(ax) + 1 >= AXES) begin
              axis_cnt[c]   = '0;
              link_state[c] = ST_WP4;
            end else begin
              axis_cnt[c] = ax + 2'd1;
            end
          end else begin
            accumulate_char(c, b);
          end
        end
        ST_WP4: if (b == CH_CR) link_state[c] = ST_WP5;
        ST_WP5: begin
          if (b == CH_LF) begin
            link_state[c] = ST_FIND;
            push_event(c, EV_END, 2'd0, 16'd0);
          end
        end
        ST_STAT: begin
          link_state[c] = ST_FIND;
          if (b == CH_UP_R) push_event(c, EV_RUN, 2'd0, 16'd0);
          else if (b == CH_UP_I) push_event(c, EV_IDLE, 2'd0, 16'd0);
          else if (b == CH_UP_A) push_event(c, EV_ALARM, 2'd0, 16'd0);
          else if (b == CH_UP_H) push_event(c, EV_HOLD, 2'd0, 16'd0);
        end
        default: link_state[c] = ST_FIND;
      endcase
    endfunction

    function void compare_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      end
    endfunction

    function void check_event(logic [1:0] ch, logic [3:0] ev, logic [1:0] ax,
                              logic [15:0] val);
      reply_t want;
      if (pending_events.size() == 0) begin
        errors++;
        $error("event with nothing pending: channel_out %0d event_code %0d", ch, ev);
        return;
      end
      want = pending_events.pop_front();
      compare_field("channel_out", int'(want.chan), int'(ch));
      compare_field("event_code", int'(want.ev), int'(ev));
      compare_field("axis_index", int'(want.axis), int'(ax));
      compare_field("axis_value", int'($signed(want.value)), int'($signed(val)));
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  bit              no_idle;
  int              beats_sent;
  int              in_calm;
  byte_q_t         msg_q;
  event_scoreboard sb = new();

  mcrp_in_if  in_bus();
  mcrp_out_if out_bus();

  motion_controller_reply_parser #(
    .CHANNELS     (CHANNELS),
    .NUMBER_CHARS (NUMBER_CHARS),
    .AXES         (AXES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("** motion_controller_reply_parser: FAILED **");
    $finish;
  end

  // Sample both channels on the rising edge; drain results before noting new bytes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_event(out_bus.channel_out, out_bus.event_code, out_bus.axis_index,
                       out_bus.axis_value);
      if (in_bus.valid && in_bus.ready)
        sb.predict_beat(func_e'(in_bus.func), in_bus.channel, in_bus.rx_byte);
    end
  end

  // Result-side backpressure: random stall bursts with calm stretches in between.
  initial begin
    int stall_left;
    int calm_left;
    stall_left    = 0;
    calm_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (no_idle) begin
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else begin
          case ($urandom_range(0, 9))
            0, 1, 2: stall_left = $urandom_range(1, 16);
            3:       calm_left  = $urandom_range(30, 200);
            default: ;
          endcase
        end
      end
    end
  end

  task automatic send_item(func_e fn, logic [1:0] ch, logic [7:0] b);
    if (!no_idle) begin
      if (in_calm > 0) in_calm--;
      else if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 16)) begin
          @(negedge clk_i);
          in_bus.valid <= 1'b0;
        end
      end else if ($urandom_range(0, 40) == 0) begin
        in_calm = $urandom_range(30, 200);
      end
    end
    @(negedge clk_i);
    in_bus.valid   <= 1'b1;
    in_bus.func    <= fn;
    in_bus.channel <= ch;
    in_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (int'(ch) < CHANNELS) beats_sent++;
  endtask

  task automatic send_text(logic [1:0] ch, string s);
    for (int i = 0; i < s.len(); i++) send_item(FN_BYTE, ch, s[i]);
  endtask

  // Send the built reply, now and then slipping a stray beat in between.
  task automatic send_msg(logic [1:0] ch);
    foreach (msg_q[i]) begin
      if ($urandom_range(0, 15) == 0)
        send_item(FN_BYTE, 2'($urandom_range(0, 3)), 8'($urandom));
      send_item(FN_BYTE, ch, msg_q[i]);
    end
  endtask

  function automatic logic [7:0] pick_byte(logic [7:0] avoid_a, logic [7:0] avoid_b);
    logic [7:0] b;
    do b = 8'($urandom); while (b == avoid_a || b == avoid_b);
    return b;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  function automatic void push_filler(logic [7:0] avoid, int max_len);
    repeat ($urandom_range(0, max_len)) msg_q.push_back(pick_byte(avoid, avoid));
  endfunction

  function automatic void push_number();
    int r;
    int n;
    repeat ($urandom_range(0, 2))
      msg_q.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
    case ($urandom_range(0, 3))
      0:       msg_q.push_back(CH_MINUS);
      1:       msg_q.push_back(CH_PLUS);
      default: ;
    endcase
    // mostly short numbers; some run past the buffer bound or overflow 16 bits
    r = $urandom_range(0, 19);
    if (r == 0) n = 0;
    else if (r < 16) n = $urandom_range(1, 5);
    else n = $urandom_range(6, 20);
    repeat (n) msg_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 3))
      0: begin
        msg_q.push_back(CH_DOT);
        repeat ($urandom_range(1, 3)) msg_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      1:       msg_q.push_back(pick_byte(CH_COMMA, CH_GT));
      default: ;
    endcase
  endfunction

  function automatic void build_reply();
    msg_q.delete();
    case ($urandom_range(0, 7))
      0: begin
        push_text("$H");
        push_filler(CH_LF, 6);
        msg_q.push_back(CH_LF);
      end
      1: push_text("ok\r\n");
      2: begin
        push_text("Re");
        push_filler(CH_LF, 6);
        msg_q.push_back(CH_LF);
      end
      3: begin
        push_text("AL");
        push_filler(CH_COLON, 6);
        push_text(": ");
        case ($urandom_range(0, 5))
          0: push_text("S");
          1: push_text("D");
          2: push_text("Ha");
          3: push_text("Ho");
          4: begin
            msg_q.push_back(CH_UP_H);
            msg_q.push_back(8'($urandom));
          end
          default: begin
            msg_q.push_back(8'($urandom));
            push_text("S");
          end
        endcase
        push_text("\r\n");
      end
      4: begin
        msg_q.push_back(CH_LT);
        case ($urandom_range(0, 4))
          0:       msg_q.push_back(CH_UP_R);
          1:       msg_q.push_back(CH_UP_I);
          2:       msg_q.push_back(CH_UP_A);
          3:       msg_q.push_back(CH_UP_H);
          default: msg_q.push_back(8'($urandom));
        endcase
        push_filler(CH_LF, 4);
        push_text("\r\n");
      end
      default: begin
        push_text("WP");
        push_filler(CH_COLON, 3);
        msg_q.push_back(CH_COLON);
        for (int a = 0; a < AXES; a++) begin
          push_number();
          msg_q.push_back((a == AXES - 1 || $urandom_range(0, 7) == 0) ? CH_GT : CH_COMMA);
        end
        push_filler(CH_CR, 3);
        push_text("\r\n");
      end
    endcase
  endfunction

  initial begin
    int         cut;
    logic [1:0] ch;
    rst_ni         = 1'b0;
    no_idle        = 1'b0;
    beats_sent     = 0;
    in_calm        = 0;
    in_bus.valid   = 1'b0;
    in_bus.func    = FN_BYTE;
    in_bus.channel = '0;
    in_bus.rx_byte = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // out-of-range link, byte extremes, wrapped and empty numbers, clear mid-report
    send_item(FN_BYTE, 2'd3, CH_LO_O);
    send_item(FN_CLEAR, 2'd3, 8'hff);
    send_item(FN_BYTE, 2'd1, 8'h00);
    send_item(FN_BYTE, 2'd1, 8'hff);
    send_text(2'd2, "WP:-32768, 65537,x>\r\n");
    send_text(2'd0, "<H");
    send_text(2'd1, "ok\r\n");
    send_text(2'd0, "WP:12");
    send_item(FN_CLEAR, 2'd0, 8'h00);
    send_text(2'd0, "$H\n");

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent >= RANDOM_BEATS - QUIET_TAIL) no_idle = 1'b1;
      ch = 2'($urandom_range(0, CHANNELS - 1));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
          if ($urandom_range(0, 9) == 0) send_item(FN_CLEAR, ch, 8'($urandom));
          build_reply();
          send_msg(ch);
        end
        14, 15: begin
          // truncate a reply and finish it with a stray byte
          build_reply();
          cut   = $urandom_range(1, msg_q.size() - 1);
          msg_q = msg_q[0:cut-1];
          msg_q.push_back(8'($urandom));
          send_msg(ch);
        end
        16, 17: repeat ($urandom_range(1, 4)) send_item(FN_BYTE, ch, 8'($urandom));
        18: send_item(FN_CLEAR, 2'($urandom_range(0, 3)), 8'($urandom));
        default: send_item(func_e'($urandom_range(0, 1)), 2'd3, 8'($urandom));
      endcase
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_events.size() == 0)
      $display("** motion_controller_reply_parser: PASSED **");
    else
      $display("** motion_controller_reply_parser: FAILED **");
    $finish;
  end

endmodule
